>>> design/wsfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfr_pkg
// Shared types and codes for the WebSocket frame receiver: parser phases,
// frame opcodes, event codes and the result record.
// ----------------------------------------------------------------------------
package wsfr_pkg;

	typedef enum logic [4:0] {
		PH_HDR0    = 5'b00001,
		PH_HDR1    = 5'b00010,
		PH_EXT     = 5'b00100,
		PH_KEY     = 5'b01000,
		PH_PAYLOAD = 5'b10000
	} phase_t;

	typedef logic [3:0] opcode_t;

	localparam opcode_t OP_CONT  = 4'h0;
	localparam opcode_t OP_TEXT  = 4'h1;
	localparam opcode_t OP_BIN   = 4'h2;
	localparam opcode_t OP_CLOSE = 4'h8;
	localparam opcode_t OP_PING  = 4'h9;

	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	localparam logic [2:0] EXT16_COUNT = 3'd1;
	localparam logic [2:0] EXT64_COUNT = 3'd7;
	localparam logic [2:0] KEY_COUNT   = 3'd3;

	typedef logic [2:0] event_t;

	localparam event_t EV_NONE   = 3'd0;
	localparam event_t EV_TEXT   = 3'd1;
	localparam event_t EV_BINARY = 3'd2;
	localparam event_t EV_PONG   = 3'd3;
	localparam event_t EV_CLOSE  = 3'd4;
	localparam event_t EV_MASK   = 3'd5;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		event_t      event_res;
		logic [15:0] close_code;
	} result_t;

endpackage
`default_nettype wire

>>> design/wsfr_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfr_in_stage
// Input register: captures one received byte per transaction and holds it
// until the parser consumes it.
// ----------------------------------------------------------------------------
module wsfr_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	input  wire logic       take,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	logic load;

	assign in_stall = valid_s1 & ~take;
	assign load     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule
`default_nettype wire

>>> design/wsfr_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfr_parser
// Frame header state machine and message tracking. Consumes one byte per
// step, updates the frame state and forms the result record for that byte.
// ----------------------------------------------------------------------------
module wsfr_parser #(
	parameter int LEN_BITS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] byte_s1,
	output wsfr_pkg::result_t res
);

	wsfr_pkg::phase_t  phase_q, phase_n;
	logic [2:0]        side_q, side_n;
	logic [LEN_BITS-1:0] rem_q, rem_n;
	logic              final_q, final_n;
	wsfr_pkg::opcode_t opcode_q, opcode_n;
	logic              masked_q, masked_n;
	logic              pend_q, pend_n;
	wsfr_pkg::opcode_t stored_q, stored_n;
	logic [1:0]        mb_q, mb_n;
	logic [15:0]       cc_q, cc_n;

	logic              hdr_done;
	logic              end_fr;
	logic [6:0]        len7;
	wsfr_pkg::opcode_t op;

	always_comb begin
		phase_n  = phase_q;
		side_n   = side_q;
		rem_n    = rem_q;
		final_n  = final_q;
		opcode_n = opcode_q;
		masked_n = masked_q;
		pend_n   = pend_q;
		stored_n = stored_q;
		mb_n     = mb_q;
		cc_n     = cc_q;
		hdr_done = 1'b0;
		end_fr   = 1'b0;
		len7     = byte_s1[6:0];
		op       = opcode_q;
		res      = '0;

		unique case (phase_q)
			wsfr_pkg::PH_HDR1: begin
				masked_n = byte_s1[7];
				if (len7 == wsfr_pkg::LEN7_EXT16) begin
					rem_n   = '0;
					side_n  = wsfr_pkg::EXT16_COUNT;
					phase_n = wsfr_pkg::PH_EXT;
				end else if (len7 == wsfr_pkg::LEN7_EXT64) begin
					rem_n   = '0;
					side_n  = wsfr_pkg::EXT64_COUNT;
					phase_n = wsfr_pkg::PH_EXT;
				end else begin
					rem_n    = {{(LEN_BITS-7){1'b0}}, len7};
					hdr_done = 1'b1;
				end
			end
			wsfr_pkg::PH_EXT: begin
				rem_n = {rem_q[LEN_BITS-9:0], byte_s1};
				if (side_q == 3'd0) begin
					hdr_done = 1'b1;
				end else begin
					side_n = side_q - 3'd1;
				end
			end
			wsfr_pkg::PH_KEY: begin
				if (side_q == 3'd0) begin
					res.event_res = wsfr_pkg::EV_MASK;
					pend_n  = 1'b0;
					mb_n    = 2'd0;
					cc_n    = 16'h0000;
					phase_n = wsfr_pkg::PH_HDR0;
				end else begin
					side_n = side_q - 3'd1;
				end
			end
			wsfr_pkg::PH_PAYLOAD: begin
				res.payload_valid = 1'b1;
				res.payload_byte  = byte_s1;
				if (mb_q == 2'd0) begin
					cc_n = {byte_s1, 8'h00};
					mb_n = 2'd1;
				end else if (mb_q == 2'd1) begin
					cc_n = cc_q | {8'h00, byte_s1};
					mb_n = 2'd2;
				end
				rem_n = rem_q - {{(LEN_BITS-1){1'b0}}, 1'b1};
				if (rem_n == '0) begin
					end_fr = 1'b1;
				end
			end
			default: begin
				final_n  = byte_s1[7];
				opcode_n = byte_s1[3:0];
				phase_n  = wsfr_pkg::PH_HDR1;
			end
		endcase

		if (hdr_done) begin
			if (masked_n) begin
				side_n  = wsfr_pkg::KEY_COUNT;
				phase_n = wsfr_pkg::PH_KEY;
			end else begin
				if (!pend_q) begin
					mb_n = 2'd0;
					cc_n = 16'h0000;
				end
				if (rem_n == '0) begin
					end_fr = 1'b1;
				end else begin
					phase_n = wsfr_pkg::PH_PAYLOAD;
				end
			end
		end

		if (end_fr) begin
			phase_n = wsfr_pkg::PH_HDR0;
			if (!final_q) begin
				if (!pend_q) begin
					stored_n = opcode_q;
					pend_n   = 1'b1;
				end
			end else begin
				if (opcode_q == wsfr_pkg::OP_CONT && stored_q != wsfr_pkg::OP_CONT) begin
					op       = stored_q;
					stored_n = wsfr_pkg::OP_CONT;
				end
				unique case (op)
					wsfr_pkg::OP_TEXT:  res.event_res = wsfr_pkg::EV_TEXT;
					wsfr_pkg::OP_BIN:   res.event_res = wsfr_pkg::EV_BINARY;
					wsfr_pkg::OP_PING:  res.event_res = wsfr_pkg::EV_PONG;
					wsfr_pkg::OP_CLOSE: begin
						res.event_res  = wsfr_pkg::EV_CLOSE;
						res.close_code = cc_n;
					end
					default:            res.event_res = wsfr_pkg::EV_NONE;
				endcase
				pend_n = 1'b0;
				mb_n   = 2'd0;
				cc_n   = 16'h0000;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wsfr_pkg::PH_HDR0;
			side_q   <= 3'd0;
			rem_q    <= '0;
			final_q  <= 1'b0;
			opcode_q <= wsfr_pkg::OP_CONT;
			masked_q <= 1'b0;
			pend_q   <= 1'b0;
			stored_q <= wsfr_pkg::OP_CONT;
			mb_q     <= 2'd0;
			cc_q     <= 16'h0000;
		end else if (step) begin
			phase_q  <= phase_n;
			side_q   <= side_n;
			rem_q    <= rem_n;
			final_q  <= final_n;
			opcode_q <= opcode_n;
			masked_q <= masked_n;
			pend_q   <= pend_n;
			stored_q <= stored_n;
			mb_q     <= mb_n;
			cc_q     <= cc_n;
		end
	end

	a_mb_range: assert property (@(posedge clk) disable iff (!arst_n)
		mb_q != 2'd3)
		else $error("message byte count out of range");

	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == wsfr_pkg::PH_PAYLOAD |-> rem_q != '0)
		else $error("payload phase with zero remaining length");

	a_key_exit: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == wsfr_pkg::PH_KEY && side_q == 3'd0
		|=> phase_q == wsfr_pkg::PH_HDR0 && !pend_q && mb_q == 2'd0)
		else $error("mask key end did not drop message");

endmodule
`default_nettype wire

>>> design/wsfr_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfr_out_stage
// Result register: holds one result record until the downstream side takes
// it, and tells the parser when a new record can be loaded.
// ----------------------------------------------------------------------------
module wsfr_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid_s1,
	input  wire wsfr_pkg::result_t res,
	output logic                   take,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output wsfr_pkg::result_t      res_q
);

	logic out_valid_q;

	assign take      = valid_s1 & (~out_valid_q | ~out_stall);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

>>> design/websocket_frame_receiver_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_receiver_core
// Parses received bytes as WebSocket frame headers, passes payload bytes out
// in order and reports message events (text, binary, pong, close, mask).
//
//   Channel | Handshake           | Payload
//   --------+---------------------+-----------------------------------------
//   in      | in_valid / in_stall | rx_byte
//   out     | out_valid/out_stall | payload_valid, payload_byte, event_res,
//           |                     | close_code
//
// One byte per cycle sustained while out_stall is low; each byte is held in the
// input register, and its result is then loaded into the result register.
// The header state update is a single pass of logic between those registers.
// out_stall holds the result register; the input register then fills and
// in_stall rises in the same cycle.
// arst_n clears all control and frame state at once.
// ----------------------------------------------------------------------------
module websocket_frame_receiver_core #(
	parameter int LEN_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             payload_valid,
	output logic [7:0]       payload_byte,
	output logic [2:0]       event_res,
	output logic [15:0]      close_code
);

	logic              take;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	wsfr_pkg::result_t res;
	wsfr_pkg::result_t res_q;

	wsfr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	wsfr_parser #(
		.LEN_BITS (LEN_BITS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (take),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	wsfr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res       (res),
		.take      (take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_q     (res_q)
	);

	assign payload_valid = res_q.payload_valid;
	assign payload_byte  = res_q.payload_byte;
	assign event_res     = res_q.event_res;
	assign close_code    = res_q.close_code;

endmodule
`default_nettype wire
